[hw/rtl/isfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_pkg
// Shared types and constants of the input-side FIR convolver.
// ----------------------------------------------------------------------------
package isfc_pkg;

  localparam int SMP_W  = 16;   // Q1.15 sample / coefficient
  localparam int PROD_W = 32;   // Q2.30 product
  localparam int SUM_W  = 40;   // partial sum, 30 fraction bits
  localparam int IDX_W  = 6;    // tap_index field
  localparam int TAP_W  = 7;    // tap_count register
  localparam int CFG_AW = 3;    // APB byte address
  localparam int CFG_DW = 32;   // APB data

  // register word index (paddr[CFG_AW-1:2])
  localparam logic [CFG_AW-3:0] REG_TAP_COUNT = 1'b0;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } isfc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_FL_RD,
    ST_FL_EMIT
  } isfc_state_t;

  // partial-sum memory controls
  typedef struct packed {
    logic rd;
    logic pop;
    logic clr_all;
  } isfc_sum_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/isfc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_in_if / isfc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface isfc_in_if;
  import isfc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [IDX_W-1:0]        tap_index;
  logic signed [SMP_W-1:0] sample_value;
  logic                    last_sample;

  modport source (output valid, opcode, tap_index, sample_value, last_sample,
                  input ready);
  modport sink   (input valid, opcode, tap_index, sample_value, last_sample,
                  output ready);
endinterface

interface isfc_out_if;
  import isfc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] result_value;
  logic                    last_result;

  modport source (output valid, result_value, last_result, input ready);
  modport sink   (input valid, result_value, last_result, output ready);
endinterface
`default_nettype wire

[hw/rtl/input_side_fir_convolver_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// input_side_fir_convolver_unit
// Input-side FIR convolution of Q1.15 audio with a Q1.15 impulse response.
// ----------------------------------------------------------------------------
// A load item (opcode 0) writes one coefficient. A sample
// item (opcode 1) walks the M = tap_count active taps through one shared
// multiply-accumulate unit: one tap per cycle is read from the coefficient
// memory and the partial-sum memory, multiplied, added and written back. The
// oldest partial sum is then emitted and the row shifts by one (a circular
// base pointer; the emitted entry is cleared through its valid bit). A sample
// item therefore goes through accept, the M tap reads, a drain that waits
// for the multiply-add pipeline to empty, and the emit step. A sample marked
// last then flushes M - 1 tail sums, each by a memory read and an emit,
// and clears the whole row at once via the valid bits, so no clearing pass
// is needed after reset either. The output register lets a finished result
// wait while the next item is accepted; a stalled output only stalls the emit
// steps. tap_count is clamped to 1..MAX_TAPS and tap_index is reduced modulo
// MAX_TAPS. Results are exact 40-bit sums with 30 fraction bits.
// ----------------------------------------------------------------------------
module input_side_fir_convolver_unit #(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  isfc_in_if.sink                             in_ch,
  isfc_out_if.source                          out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [isfc_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [isfc_pkg::CFG_DW-1:0]    pwdata,
  output      logic [isfc_pkg::CFG_DW-1:0]    prdata,
  output      logic                           pready
);
  import isfc_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int RW = IDX_W + 7;   // reduction width for modulo steps

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [TAP_W-1:0] tap_count_r;
  logic             cfg_wr;
  logic             reg_hit;

  assign reg_hit = (paddr[CFG_AW-1:2] == REG_TAP_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(CFG_DW-TAP_W){1'b0}}, tap_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_W'(1);
    end else if (cfg_wr) begin
      tap_count_r <= pwdata[TAP_W-1:0];
    end
  end

  // clamp to 1..MAX_TAPS
  logic [TAP_W-1:0] taps_clamp;
  always_comb begin
    if (tap_count_r == '0) begin
      taps_clamp = TAP_W'(1);
    end else if (tap_count_r > TAP_W'(MAX_TAPS)) begin
      taps_clamp = TAP_W'(MAX_TAPS);
    end else begin
      taps_clamp = tap_count_r;
    end
  end

  // tap_index mod MAX_TAPS: restoring conditional subtracts
  logic [RW-1:0] slot_red;
  logic [AW-1:0] slot;
  always_comb begin
    slot_red = RW'(in_ch.tap_index);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (slot_red >= RW'(MAX_TAPS << k)) begin
        slot_red = slot_red - RW'(MAX_TAPS << k);
      end
    end
  end
  assign slot = slot_red[AW-1:0];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(MAX_TAPS - 1)) ? '0 : p + AW'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  isfc_state_t             state_r, state_nxt;
  logic [CW-1:0]           taps_r, taps_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic [AW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]           base_r, base_nxt;
  logic                    last_r, last_nxt;
  logic signed [SMP_W-1:0] sample_r, sample_nxt;
  logic [SUM_W-1:0]        head_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]        out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_acc;
  logic                    out_free;
  logic                    issue;
  isfc_sum_ctrl_t          sctl;
  logic [AW-1:0]           sum_rd_addr;

  // memory / MAC wiring
  logic signed [SMP_W-1:0] coef_q;
  logic [SUM_W-1:0]        sum_q;
  logic                    mac_wr_en, mac_wr_first, mac_busy;
  logic [AW-1:0]           mac_wr_addr;
  logic [SUM_W-1:0]        mac_wr_data;
  logic                    coef_wr;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign coef_wr  = in_acc && (in_ch.opcode == OP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    taps_r      <= taps_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    last_r      <= last_nxt;
    sample_r    <= sample_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    if (mac_wr_en && mac_wr_first) begin
      head_r <= mac_wr_data;   // updated logical tap 0 = next result
    end
  end

  always_comb begin
    state_nxt     = state_r;
    taps_nxt      = taps_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    rd_ptr_nxt    = rd_ptr_r;
    base_nxt      = base_r;
    last_nxt      = last_r;
    sample_nxt    = sample_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    in_ch.ready   = 1'b0;
    issue         = 1'b0;
    sctl          = '0;
    sum_rd_addr   = rd_ptr_r;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && (in_ch.opcode == OP_SAMPLE)) begin
          sample_nxt = in_ch.sample_value;
          last_nxt   = in_ch.last_sample;
          taps_nxt   = taps_clamp[CW-1:0];
          cnt_nxt    = '0;
          rd_ptr_nxt = base_r;
          state_nxt  = ST_MAC;
        end
      end

      // one tap per cycle into the MAC pipeline
      ST_MAC: begin
        issue      = 1'b1;
        sctl.rd    = 1'b1;
        cnt_nxt    = cnt_r + CW'(1);
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        if (cnt_r == taps_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_EMIT;
        end
      end

      // normal output: the updated head of the row
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = head_r;
          out_last_nxt  = last_r && (taps_r == CW'(1));
          sctl.pop      = 1'b1;
          base_nxt      = ptr_inc(base_r);
          if (last_r && (taps_r != CW'(1))) begin
            rem_nxt   = taps_r - CW'(1);
            state_nxt = ST_FL_RD;
          end else begin
            sctl.clr_all = last_r;
            state_nxt    = ST_IDLE;
          end
        end
      end

      // tail flush: read head, then emit and pop
      ST_FL_RD: begin
        sctl.rd     = 1'b1;
        sum_rd_addr = base_r;
        state_nxt   = ST_FL_EMIT;
      end

      ST_FL_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = sum_q;
          out_last_nxt  = (rem_r == CW'(1));
          sctl.pop      = 1'b1;
          base_nxt      = ptr_inc(base_r);
          rem_nxt       = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            sctl.clr_all = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_FL_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.last_result  = out_last_r;

  // --------------------------------------------------------------------------
  // Memories and MAC
  // --------------------------------------------------------------------------
  isfc_coef_ram #(
    .DEPTH (MAX_TAPS),
    .AW    (AW)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (slot),
    .wr_data (in_ch.sample_value),
    .rd_en   (issue),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (coef_q)
  );

  isfc_sum_ram #(
    .DEPTH (MAX_TAPS),
    .AW    (AW)
  ) u_sum_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (sctl),
    .rd_addr  (sum_rd_addr),
    .pop_addr (base_r),
    .wr_en    (mac_wr_en),
    .wr_addr  (mac_wr_addr),
    .wr_data  (mac_wr_data),
    .rd_data  (sum_q)
  );

  isfc_mac #(
    .AW (AW)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue       (issue),
    .issue_addr  (rd_ptr_r),
    .issue_first (cnt_r == '0),
    .sample      (sample_r),
    .coef        (coef_q),
    .sum_in      (sum_q),
    .wr_en       (mac_wr_en),
    .wr_addr     (mac_wr_addr),
    .wr_data     (mac_wr_data),
    .wr_first    (mac_wr_first),
    .busy        (mac_busy)
  );

endmodule
`default_nettype wire

[hw/rtl/isfc_coef_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_coef_ram
// Coefficient store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module isfc_coef_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [AW-1:0]                    wr_addr,
  input  wire logic signed [isfc_pkg::SMP_W-1:0] wr_data,
  input  wire logic                             rd_en,
  input  wire logic [AW-1:0]                    rd_addr,
  output      logic signed [isfc_pkg::SMP_W-1:0] rd_data
);
  import isfc_pkg::*;

  logic signed [SMP_W-1:0] mem [DEPTH];
  logic signed [SMP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[hw/rtl/isfc_sum_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_sum_ram
// Partial-sum row in a circular memory. Per-entry valid bits make a cleared
// entry read as zero; pop clears one entry, clr_all clears the row.
// ----------------------------------------------------------------------------
module isfc_sum_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire isfc_pkg::isfc_sum_ctrl_t          ctrl,
  input  wire logic [AW-1:0]                     rd_addr,
  input  wire logic [AW-1:0]                     pop_addr,
  input  wire logic                              wr_en,
  input  wire logic [AW-1:0]                     wr_addr,
  input  wire logic [isfc_pkg::SUM_W-1:0]        wr_data,
  output      logic [isfc_pkg::SUM_W-1:0]        rd_data
);
  import isfc_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctrl.rd) begin
        rd_vld_r <= valid_r[rd_addr];
      end
      if (ctrl.clr_all) begin
        valid_r <= '0;
      end else begin
        if (wr_en) begin
          valid_r[wr_addr] <= 1'b1;
        end
        if (ctrl.pop) begin
          valid_r[pop_addr] <= 1'b0;
        end
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

[hw/rtl/isfc_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_mac
// Two-stage multiply-accumulate behind the memory reads: product register,
// then 40-bit add and write back.
// ----------------------------------------------------------------------------
module isfc_mac #(
  parameter int AW = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              issue,
  input  wire logic [AW-1:0]                     issue_addr,
  input  wire logic                              issue_first,
  input  wire logic signed [isfc_pkg::SMP_W-1:0] sample,
  input  wire logic signed [isfc_pkg::SMP_W-1:0] coef,
  input  wire logic [isfc_pkg::SUM_W-1:0]        sum_in,
  output      logic                              wr_en,
  output      logic [AW-1:0]                     wr_addr,
  output      logic [isfc_pkg::SUM_W-1:0]        wr_data,
  output      logic                              wr_first,
  output      logic                              busy
);
  import isfc_pkg::*;

  // stage 1: memory data valid
  logic          v1_r, f1_r;
  logic [AW-1:0] a1_r;
  // stage 2: product registered
  logic                     v2_r, f2_r;
  logic [AW-1:0]            a2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= issue_addr;
    f1_r   <= issue_first;
    a2_r   <= a1_r;
    f2_r   <= f1_r;
    prod_r <= sample * coef;
    acc_r  <= sum_in;
  end

  assign wr_en    = v2_r;
  assign wr_addr  = a2_r;
  assign wr_first = f2_r;
  assign wr_data  = acc_r + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign busy     = v1_r | v2_r;

endmodule
`default_nettype wire

[hw/rtl/isfc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isfc_checker
// Port-level checks of the convolver, bound to the top level.
// ----------------------------------------------------------------------------
module isfc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_opcode,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [isfc_pkg::SUM_W-1:0]   out_value,
  input wire logic                         out_last
);
  import isfc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  // a sample item keeps the input closed while its taps are processed
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_SAMPLE) |=> !in_ready)
    else $error("input reopened right after a sample item");

  // a load item never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("result after a load item");

  // the input is closed while a result for a sample is being emitted
  a_emit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> !$past(in_ready))
    else $error("result appeared from the idle state");

endmodule

bind input_side_fir_convolver_unit isfc_checker u_isfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.result_value),
  .out_last  (out_ch.last_result)
);
`default_nettype wire
